FILE: rtl/core/rar_pkg.sv
// shared types, widths and limits of the fraction arithmetic and reduction block
`default_nettype none
package rar_pkg;

   // operand width and the widths that follow from it
   localparam int OPERAND_WIDTH = 16;
   localparam int PROD_W = 2 * OPERAND_WIDTH;
   localparam int MAG_W = PROD_W + 1;
   localparam int CNT_W = $clog2(MAG_W);
   localparam int NUM_W = 32;
   localparam int DEN_W = 30;
   localparam int CMP_W = (MAG_W > NUM_W + 1) ? MAG_W : NUM_W + 1;

   // saturation limits of the result fields
   localparam logic [CMP_W-1:0] NUM_POS_LIM = CMP_W'(64'h0000_0000_7FFF_FFFF);
   localparam logic [CMP_W-1:0] NUM_NEG_LIM = CMP_W'(64'h0000_0000_8000_0000);
   localparam logic [CMP_W-1:0] DEN_LIM = CMP_W'(64'h0000_0000_3FFF_FFFF);

   typedef enum logic [1:0] {
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV
   } op_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_ZERO_DEN,
      ST_DIV_ZERO
   } status_type;

   // which cross product the shared multiplier forms
   typedef enum logic [1:0] {
      MSEL_A,
      MSEL_B,
      MSEL_D
   } msel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL0,
      S_MUL1,
      S_MUL2,
      S_COMB,
      S_LOAD,
      S_GCD,
      S_DIV,
      S_FIN
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic     capture;
      logic     mul_en;
      msel_type mul_sel;
      logic     comb;
      logic     load;
      logic     gcd_step;
      logic     div_init;
      logic     div_step;
      logic     out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic err;
      logic gcd_done;
      logic div_done;
   } sts_type;

endpackage
`default_nettype wire

FILE: rtl/core/rar_if.sv
// request and response channel interfaces of the fraction block
`default_nettype none
interface rar_req_if
   import rar_pkg::*;
   ();
   logic                             valid;
   logic                             ready;
   op_type                           opcode;
   logic signed [OPERAND_WIDTH-1:0]  a_num;
   logic signed [OPERAND_WIDTH-1:0]  a_den;
   logic signed [OPERAND_WIDTH-1:0]  b_num;
   logic signed [OPERAND_WIDTH-1:0]  b_den;

   modport source (output valid, output opcode, output a_num, output a_den,
                   output b_num, output b_den, input ready);
   modport sink (input valid, input opcode, input a_num, input a_den,
                 input b_num, input b_den, output ready);
endinterface

interface rar_rsp_if
   import rar_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic signed [NUM_W-1:0]  res_num;
   logic [DEN_W-1:0]         res_den;
   status_type               status;

   modport source (output valid, output res_num, output res_den, output status,
                   input ready);
   modport sink (input valid, input res_num, input res_den, input status,
                 output ready);
endinterface
`default_nettype wire

FILE: rtl/core/rar_ctrl.sv
// sequencing state machine of the fraction block
`default_nettype none
module rar_ctrl
   import rar_pkg::*;
   (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire logic    rsp_ready,
   output logic         rsp_valid,
   input  wire sts_type sts,
   output cmd_type      cmd
   );

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // state and output beat flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_MUL0;
            end
         end
         S_MUL0: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MSEL_A;
            state_in    = sts.err ? S_FIN : S_MUL1;
         end
         S_MUL1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MSEL_B;
            state_in    = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MSEL_D;
            state_in    = S_COMB;
         end
         S_COMB: begin
            cmd.comb = 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = S_GCD;
         end
         S_GCD: begin
            if (sts.gcd_done) begin
               cmd.div_init = 1'b1;
               state_in     = S_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output beat held until taken
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

FILE: rtl/core/rar_dpath.sv
// datapath: cross products, binary gcd, exact division and result register
`default_nettype none
module rar_dpath
   import rar_pkg::*;
   (
   input  wire logic                            clock,
   input  wire op_type                          opcode,
   input  wire logic signed [OPERAND_WIDTH-1:0] a_num,
   input  wire logic signed [OPERAND_WIDTH-1:0] a_den,
   input  wire logic signed [OPERAND_WIDTH-1:0] b_num,
   input  wire logic signed [OPERAND_WIDTH-1:0] b_den,
   input  wire cmd_type                         cmd,
   output sts_type                              sts,
   output logic signed [NUM_W-1:0]              res_num,
   output logic [DEN_W-1:0]                     res_den,
   output status_type                           status
   );

   // operand registers
   op_type                          op_ff;
   logic signed [OPERAND_WIDTH-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   status_type                      err_ff, err_in;

   // products and signed numerator
   logic signed [OPERAND_WIDTH-1:0] mx, my;
   logic signed [PROD_W-1:0]        prod;
   logic signed [PROD_W-1:0]        pa_ff, pb_ff, pd_ff;
   logic signed [MAG_W-1:0]         pa_x, pb_x, den_x, num_ff, num_in;
   logic [MAG_W-1:0]                num_mag, den_mag;
   logic                            neg_ff;

   // gcd and divider registers
   logic [MAG_W-1:0]                gx_ff, gx_in, gy_ff, gy_in;
   logic [MAG_W-1:0]                qn_ff, qn_in, qd_ff, qd_in;
   logic [MAG_W-1:0]                rn_ff, rn_in, rd_ff, rd_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic [MAG_W:0]                  rn_try, rd_try;
   logic [MAG_W-1:0]                gdiff_xy, gdiff_yx;

   // output formatting
   logic [CMP_W-1:0]                qn_w, qd_w;
   logic                            neg_res;
   logic [NUM_W-1:0]                mag32;
   logic signed [NUM_W-1:0]         res_num_ff, res_num_in;
   logic [DEN_W-1:0]                res_den_ff, res_den_in;
   status_type                      status_ff;

   // input check on the incoming beat
   always_comb begin
      if (a_den == '0 || b_den == '0) begin
         err_in = ST_ZERO_DEN;
      end else if (opcode == OP_DIV && b_num == '0) begin
         err_in = ST_DIV_ZERO;
      end else begin
         err_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= opcode;
         an_ff  <= a_num;
         ad_ff  <= a_den;
         bn_ff  <= b_num;
         bd_ff  <= b_den;
         err_ff <= err_in;
      end
   end

   // shared multiplier, one cross product a cycle
   always_comb begin
      case (cmd.mul_sel)
         MSEL_A: begin
            mx = an_ff;
            my = (op_ff == OP_MUL) ? bn_ff : bd_ff;
         end
         MSEL_B: begin
            mx = bn_ff;
            my = ad_ff;
         end
         MSEL_D: begin
            mx = ad_ff;
            my = (op_ff == OP_DIV) ? bn_ff : bd_ff;
         end
         default: begin
            mx = an_ff;
            my = bd_ff;
         end
      endcase
   end

   assign prod = PROD_W'(mx) * PROD_W'(my);

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         case (cmd.mul_sel)
            MSEL_A:  pa_ff <= prod;
            MSEL_B:  pb_ff <= prod;
            MSEL_D:  pd_ff <= prod;
            default: pa_ff <= prod;
         endcase
      end
   end

   // numerator from the cross products
   assign pa_x = {pa_ff[PROD_W-1], pa_ff};
   assign pb_x = {pb_ff[PROD_W-1], pb_ff};
   assign den_x = {pd_ff[PROD_W-1], pd_ff};

   always_comb begin
      case (op_ff)
         OP_ADD:  num_in = pa_x + pb_x;
         OP_SUB:  num_in = pa_x - pb_x;
         default: num_in = pa_x;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.comb) begin
         num_ff <= num_in;
      end
   end

   // magnitudes for the reduction
   assign num_mag = num_ff[MAG_W-1] ? (~num_ff + 1'b1) : num_ff;
   assign den_mag = den_x[MAG_W-1] ? (~den_x + 1'b1) : den_x;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         neg_ff <= num_ff[MAG_W-1] ^ pd_ff[PROD_W-1];
      end
   end

   // binary gcd step; common factors of two are taken out of both quotients
   assign gdiff_xy = gx_ff - gy_ff;
   assign gdiff_yx = gy_ff - gx_ff;

   // restoring division of both values by the odd gcd part
   assign rn_try = {rn_ff, qn_ff[MAG_W-1]};
   assign rd_try = {rd_ff, qd_ff[MAG_W-1]};

   always_comb begin
      gx_in  = gx_ff;
      gy_in  = gy_ff;
      qn_in  = qn_ff;
      qd_in  = qd_ff;
      rn_in  = rn_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (cmd.load) begin
         gx_in = num_mag;
         gy_in = den_mag;
         qn_in = num_mag;
         qd_in = den_mag;
      end else if (cmd.gcd_step) begin
         if (!gx_ff[0] && !gy_ff[0]) begin
            gx_in = gx_ff >> 1;
            gy_in = gy_ff >> 1;
            qn_in = qn_ff >> 1;
            qd_in = qd_ff >> 1;
         end else if (!gx_ff[0]) begin
            gx_in = gx_ff >> 1;
         end else if (!gy_ff[0]) begin
            gy_in = gy_ff >> 1;
         end else if (gx_ff >= gy_ff) begin
            gx_in = gdiff_xy >> 1;
         end else begin
            gy_in = gdiff_yx >> 1;
         end
      end else if (cmd.div_init) begin
         rn_in  = '0;
         rd_in  = '0;
         cnt_in = '0;
      end else if (cmd.div_step) begin
         if (rn_try >= {1'b0, gy_ff}) begin
            rn_in = MAG_W'(rn_try - {1'b0, gy_ff});
            qn_in = {qn_ff[MAG_W-2:0], 1'b1};
         end else begin
            rn_in = rn_try[MAG_W-1:0];
            qn_in = {qn_ff[MAG_W-2:0], 1'b0};
         end
         if (rd_try >= {1'b0, gy_ff}) begin
            rd_in = MAG_W'(rd_try - {1'b0, gy_ff});
            qd_in = {qd_ff[MAG_W-2:0], 1'b1};
         end else begin
            rd_in = rd_try[MAG_W-1:0];
            qd_in = {qd_ff[MAG_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      gx_ff  <= gx_in;
      gy_ff  <= gy_in;
      qn_ff  <= qn_in;
      qd_ff  <= qd_in;
      rn_ff  <= rn_in;
      rd_ff  <= rd_in;
      cnt_ff <= cnt_in;
   end

   assign sts.err      = (err_ff != ST_OK);
   assign sts.gcd_done = (gx_ff == '0);
   assign sts.div_done = (cnt_ff == CNT_W'(MAG_W - 1));

   // sign, saturation and error zeroing
   assign qn_w    = CMP_W'(qn_ff);
   assign qd_w    = CMP_W'(qd_ff);
   assign neg_res = neg_ff && (qn_ff != '0);

   always_comb begin
      if (neg_res) begin
         mag32 = (qn_w > NUM_NEG_LIM) ? NUM_NEG_LIM[NUM_W-1:0] : qn_w[NUM_W-1:0];
      end else begin
         mag32 = (qn_w > NUM_POS_LIM) ? NUM_POS_LIM[NUM_W-1:0] : qn_w[NUM_W-1:0];
      end
      if (err_ff != ST_OK) begin
         res_num_in = '0;
         res_den_in = '0;
      end else begin
         res_num_in = neg_res ? (~mag32 + 1'b1) : mag32;
         res_den_in = (qd_w > DEN_LIM) ? DEN_LIM[DEN_W-1:0] : qd_w[DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         res_num_ff <= res_num_in;
         res_den_ff <= res_den_in;
         status_ff  <= err_ff;
      end
   end

   assign res_num = res_num_ff;
   assign res_den = res_den_ff;
   assign status  = status_ff;

endmodule
`default_nettype wire

FILE: rtl/core/rational_arith_reduce.sv
// Fraction calculator: add, subtract, multiply or divide two signed fractions
// and reduce the result to lowest terms with a positive denominator.
// req_ch carries one beat per operation (opcode and both fractions); rsp_ch
// returns one beat with the reduced numerator, denominator and status.
// An operation runs from a single shared multiplier (three cross products,
// one a cycle), a binary gcd unit that does one subtract-and-shift step a
// cycle, and a bit-serial divider that divides numerator and denominator by
// the gcd together, one quotient bit a cycle.
// The gcd runs until its first value reaches zero, so the run time depends
// on the operands; a zero denominator or a division by a zero fraction
// skips the remaining arithmetic and goes straight to the response register.
// One operation is in flight at a time; req_ch is ready again once the
// result sits in the response register, so a new beat is taken while the
// last result still waits. A stalled receiver holds rsp_ch steady and the
// next finished result waits until the response register frees.
// Reset (synchronous, active high) returns to idle with no response pending.
`default_nettype none
module rational_arith_reduce
   import rar_pkg::*;
   (
   input  wire logic  clock,
   input  wire logic  reset,
   rar_req_if.sink    req_ch,
   rar_rsp_if.source  rsp_ch
   );

   cmd_type cmd;
   sts_type sts;

   // sequencer
   rar_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   // arithmetic and result register
   rar_dpath u_dpath (
      .clock   (clock),
      .opcode  (req_ch.opcode),
      .a_num   (req_ch.a_num),
      .a_den   (req_ch.a_den),
      .b_num   (req_ch.b_num),
      .b_den   (req_ch.b_den),
      .cmd     (cmd),
      .sts     (sts),
      .res_num (rsp_ch.res_num),
      .res_den (rsp_ch.res_den),
      .status  (rsp_ch.status)
   );

endmodule
`default_nettype wire

FILE: tb/rar_checker.sv
// result checker for the fraction block: predicts each request beat and compares responses
`default_nettype none
module rar_checker
   import rar_pkg::*;
   (
   input  wire logic clock,
   input  wire logic reset,
   rar_req_if        req_ch,
   rar_rsp_if        rsp_ch,
   output int        failures,
   output int        outstanding,
   output int        checked,
   output int        flagged
   );

   typedef struct {
      op_type                          opcode;
      logic signed [OPERAND_WIDTH-1:0] a_num;
      logic signed [OPERAND_WIDTH-1:0] a_den;
      logic signed [OPERAND_WIDTH-1:0] b_num;
      logic signed [OPERAND_WIDTH-1:0] b_den;
   } frac_op_type;

   typedef struct {
      logic signed [NUM_W-1:0] num;
      logic [DEN_W-1:0]        den;
      status_type              status;
   } frac_res_type;

   frac_res_type reduced_q[$];
   frac_op_type  seen_op;
   frac_res_type want;

   initial begin
      failures = 0;
      outstanding = 0;
      checked = 0;
      flagged = 0;
   end

   // cross multiply, reduce by the gcd of the magnitudes, then saturate
   function automatic frac_res_type reduce_fraction(frac_op_type op);
      longint            an, ad, bn, bd, top, bot;
      longint unsigned   nmag, dmag, x, y, r;
      bit                neg;
      frac_res_type      res;
      an = op.a_num;
      ad = op.a_den;
      bn = op.b_num;
      bd = op.b_den;
      res.num = '0;
      res.den = '0;
      res.status = ST_OK;
      // a zero denominator takes priority over a zero divisor
      if (ad == 0 || bd == 0) begin
         res.status = ST_ZERO_DEN;
         return res;
      end
      if (op.opcode == OP_DIV && bn == 0) begin
         res.status = ST_DIV_ZERO;
         return res;
      end
      case (op.opcode)
         OP_ADD: begin
            top = an * bd + bn * ad;
            bot = ad * bd;
         end
         OP_SUB: begin
            top = an * bd - bn * ad;
            bot = ad * bd;
         end
         OP_MUL: begin
            top = an * bn;
            bot = ad * bd;
         end
         default: begin
            top = an * bd;
            bot = ad * bn;
         end
      endcase
      neg = (top < 0) != (bot < 0);
      nmag = (top < 0) ? longint'(-top) : longint'(top);
      dmag = (bot < 0) ? longint'(-bot) : longint'(bot);
      x = nmag;
      y = dmag;
      while (y != 0) begin
         r = x % y;
         x = y;
         y = r;
      end
      nmag = nmag / x;
      dmag = dmag / x;
      // zero comes out as a positive 0/1
      if (nmag == 0)
         neg = 0;
      if (neg) begin
         if (nmag > 64'h8000_0000)
            nmag = 64'h8000_0000;
         nmag = -nmag;
      end else if (nmag > 64'h7FFF_FFFF) begin
         nmag = 64'h7FFF_FFFF;
      end
      if (dmag > 64'h3FFF_FFFF)
         dmag = 64'h3FFF_FFFF;
      res.num = nmag[NUM_W-1:0];
      res.den = dmag[DEN_W-1:0];
      return res;
   endfunction

   task automatic report_mismatch(string what, longint got, longint exp_val);
      failures++;
      $display("mismatch on response %0d: %s is %0d, expected %0d",
               checked, what, got, exp_val);
   endtask

   // queue a prediction per request beat, compare each response beat in order
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            seen_op.opcode = req_ch.opcode;
            seen_op.a_num = req_ch.a_num;
            seen_op.a_den = req_ch.a_den;
            seen_op.b_num = req_ch.b_num;
            seen_op.b_den = req_ch.b_den;
            reduced_q.push_back(reduce_fraction(seen_op));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (reduced_q.size() == 0) begin
               report_mismatch("unrequested response beat, res_num", rsp_ch.res_num, 0);
            end else begin
               want = reduced_q.pop_front();
               if (rsp_ch.res_num !== want.num)
                  report_mismatch("res_num", rsp_ch.res_num, want.num);
               if (rsp_ch.res_den !== want.den)
                  report_mismatch("res_den", rsp_ch.res_den, want.den);
               if (rsp_ch.status !== want.status)
                  report_mismatch("status", rsp_ch.status, want.status);
               if (want.status != ST_OK)
                  flagged++;
               checked++;
            end
         end
         outstanding <= reduced_q.size();
      end
   end

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// top of the fraction block testbench: clock, reset, stimulus, back-pressure and verdict
`default_nettype none
module tb_top;
   import rar_pkg::*;

   localparam int RANDOM_OPS = 1625;
   localparam int QUIET_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 150;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   steady = 1'b0;
   int   quiet_cycles = 0;
   int   op_count[4];
   int   failures, outstanding, checked, flagged;

   rar_req_if req_ch();
   rar_rsp_if rsp_ch();

   rational_arith_reduce uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   rar_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .failures    (failures),
      .outstanding (outstanding),
      .checked     (checked),
      .flagged     (flagged)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // receiver back-pressure, none during the steady stretch
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= steady || ($urandom_range(99) >= 12);
      end
   end

   // give up when neither channel moves a beat for too long
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no beat for %0d cycles, %0d responses pending",
                  QUIET_LIMIT, outstanding);
         $display("[rational_arith_reduce] ERROR");
         $finish;
      end
   end

   // present one request beat from a falling edge and hold it until taken
   task automatic send_op(op_type op, logic signed [OPERAND_WIDTH-1:0] an,
                          logic signed [OPERAND_WIDTH-1:0] ad,
                          logic signed [OPERAND_WIDTH-1:0] bn,
                          logic signed [OPERAND_WIDTH-1:0] bd);
      if (!steady) begin
         while ($urandom_range(99) < 12) begin
            req_ch.valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.a_num <= an;
      req_ch.a_den <= ad;
      req_ch.b_num <= bn;
      req_ch.b_den <= bd;
      op_count[op]++;
      do
         @(posedge clock);
      while (!req_ch.ready);
      @(negedge clock);
   endtask

   // small values give common factors, full-width values exercise every bit
   function automatic logic signed [OPERAND_WIDTH-1:0] pick_operand(bit nonzero);
      logic signed [OPERAND_WIDTH-1:0] v;
      case ($urandom_range(9))
         0, 1, 2: v = OPERAND_WIDTH'($urandom_range(40)) - OPERAND_WIDTH'(20);
         3: begin
            case ($urandom_range(3))
               0: v = 32767;
               1: v = -32767;
               2: v = -32768;
               default: v = -1;
            endcase
         end
         default: v = OPERAND_WIDTH'($urandom());
      endcase
      if (nonzero && v == 0)
         v = 1;
      return v;
   endfunction

   initial begin
      logic signed [OPERAND_WIDTH-1:0] an, ad, bn, bd;
      op_type op;
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_ADD;
      req_ch.a_num = '0;
      req_ch.a_den = '0;
      req_ch.b_num = '0;
      req_ch.b_den = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: each operation, sign handling, extremes and the error paths
      send_op(OP_ADD, 1, 2, 1, 3);
      send_op(OP_SUB, 5, 7, 3, 7);
      send_op(OP_MUL, -3, 4, 8, -9);
      send_op(OP_DIV, 2, 3, -4, 5);
      send_op(OP_ADD, 3, -4, 5, -6);
      send_op(OP_SUB, 3, 4, 3, 4);
      send_op(OP_SUB, 0, 5, 0, -3);
      send_op(OP_ADD, 7, 0, 1, 2);
      send_op(OP_MUL, 7, 3, 1, 0);
      send_op(OP_DIV, 0, 0, 0, 0);
      send_op(OP_DIV, 3, 4, 0, 5);
      send_op(OP_DIV, 0, 4, 3, 5);
      send_op(OP_ADD, 32767, 32767, -32767, -32767);
      send_op(OP_MUL, 32767, 1, 32767, 1);
      send_op(OP_DIV, 1, 32767, 32767, 1);
      send_op(OP_SUB, -32767, 32766, 32767, -32765);
      send_op(OP_MUL, -32768, 1, -32768, 1);
      send_op(OP_MUL, 1, -32768, 1, -32768);
      send_op(OP_DIV, -32768, -1, -32768, 32767);
      send_op(OP_ADD, -32768, -32768, -32768, -32768);
      send_op(OP_SUB, -1, -1, -1, 1);
      send_op(OP_DIV, -32767, 2, -1, 32767);

      // random: mostly valid fractions, some zero denominators and divisors
      for (int i = 0; i < RANDOM_OPS; i++) begin
         steady = (i >= 700 && i < 1000);
         op = op_type'($urandom_range(3));
         an = pick_operand(0);
         ad = ($urandom_range(99) < 3) ? '0 : pick_operand(1);
         bn = ($urandom_range(99) < 4) ? '0 : pick_operand(0);
         bd = ($urandom_range(99) < 3) ? '0 : pick_operand(1);
         if ($urandom_range(9) == 0)
            bd = ad;
         if ($urandom_range(19) == 0) begin
            bn = an;
            bd = ad;
         end
         send_op(op, an, ad, bn, bd);
      end
      steady = 1'b0;
      req_ch.valid <= 1'b0;

      // drain, then leave time for any stray response
      while (outstanding != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d operations: %0d add, %0d subtract, %0d multiply, %0d divide",
               op_count[0] + op_count[1] + op_count[2] + op_count[3],
               op_count[0], op_count[1], op_count[2], op_count[3]);
      $display("compared %0d responses, %0d of them error statuses; %0d mismatches",
               checked, flagged, failures);
      if (failures == 0)
         $display("[rational_arith_reduce] OK");
      else
         $display("[rational_arith_reduce] ERROR");
      $finish;
   end

endmodule
`default_nettype wire
